// ===== src/ptm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants of the two-level page table manager.
// ----------------------------------------------------------------------------
package ptm_pkg;

  // size of the page table pool
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int USED_W      = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_DEPTH   = 1024;
  localparam int TAB_LEN     = 1024;
  localparam int TAB_DEPTH   = (1 << SLOT_W) * TAB_LEN;
  localparam int DIR_W       = 24;
  localparam int PTE_W       = 23;

  // directory entry bits
  localparam int D_P  = 0;
  localparam int D_RW = 1;
  localparam int D_US = 2;
  localparam int D_PS = 7;

  // table entry bits
  localparam int T_P  = 20;

  localparam logic [10:0] DIR_COUNT = 11'd1024;
  localparam logic [10:0] IDENT_RESET = 11'd224;

  typedef enum logic [2:0] {
    OP_MAP   = 3'd0,
    OP_UNMAP = 3'd1,
    OP_PROBE = 3'd2,
    OP_DROP  = 3'd3,
    OP_LOAD  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LARGE      = 3'd1,
    ST_NO_SLOT    = 3'd2,
    ST_MAPPED     = 3'd3,
    ST_NOT_MAPPED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DRD,
    S_TRD,
    S_EXEC,
    S_TCLR,
    S_DROP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic pde_load;
    logic exec;
    logic clr;
    logic tclr;
    logic drop;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic new_slot;
    logic is_drop;
    logic drop_empty;
    logic out_free;
  } stat_t;

endpackage

// ===== src/ptm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/ptm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer: reset clear, read directory, read table, execute, sweeps, result.
// ----------------------------------------------------------------------------
module ptm_ctrl import ptm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (st.last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DRD;
      S_DRD:  state_next = S_TRD;
      S_TRD:  state_next = S_EXEC;
      S_EXEC: begin
        if (st.new_slot) begin
          state_next = S_TCLR;
        end else if (st.is_drop && !st.drop_empty) begin
          state_next = S_DROP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TCLR: if (st.last) state_next = S_DONE;
      S_DROP: if (st.last) state_next = S_DONE;
      S_DONE: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    case (state)
      S_CLR:  cmd.clr = 1'b1;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_DRD:  ;
      S_TRD:  cmd.pde_load = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_TCLR: cmd.tclr = 1'b1;
      S_DROP: cmd.drop = 1'b1;
      S_DONE: cmd.done = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/ptm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_datapath
// Directory and table memories, slot counter, decision logic, result register.
// ----------------------------------------------------------------------------
module ptm_datapath import ptm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [10:0] identity_entries,
  input  logic [2:0]  operation,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic        writable,
  input  logic        user_access,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] translated,
  output logic        hit,
  output logic        invalidate_page,
  output logic        flush_all
);

  localparam int TAW = $clog2(TAB_DEPTH);

  // captured transaction
  logic [2:0]  op_q;
  logic [31:0] va_q;
  logic [31:0] pa_q;
  logic        wr_q;
  logic        us_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      va_q <= virt_addr;
      pa_q <= phys_addr;
      wr_q <= writable;
      us_q <= user_access;
    end
  end

  logic [9:0] di;
  logic [9:0] ti;
  assign di = va_q[31:22];
  assign ti = va_q[21:12];

  // sweep counter
  logic [10:0] cnt;
  logic        sweeping;
  assign sweeping = cmd.clr | cmd.tclr | cmd.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= sweeping ? cnt + 11'd1 : '0;
    end
  end

  // drop count saturates at the directory size
  logic [10:0] drop_n;
  assign drop_n = (identity_entries > DIR_COUNT) ? DIR_COUNT : identity_entries;

  // memories
  logic             dir_we;
  logic [9:0]       dir_addr;
  logic [DIR_W-1:0] dir_wdata;
  logic [DIR_W-1:0] dir_rdata;
  logic             tab_we;
  logic [TAW-1:0]   tab_addr;
  logic [PTE_W-1:0] tab_wdata;
  logic [PTE_W-1:0] tab_rdata;

  ptm_ram #(.WIDTH(DIR_W), .DEPTH(DIR_DEPTH)) u_dir (
    .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata)
  );

  ptm_ram #(.WIDTH(PTE_W), .DEPTH(TAB_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata(tab_wdata), .rdata(tab_rdata)
  );

  // held directory entry
  logic [DIR_W-1:0] pde_q;
  always_ff @(posedge clk) begin
    if (cmd.pde_load) begin
      pde_q <= dir_rdata;
    end
  end

  logic [DIR_W-1:0] pde_src;
  assign pde_src = cmd.pde_load ? dir_rdata : pde_q;

  // slot allocation
  logic [USED_W-1:0] tables_used;
  logic [SLOT_W-1:0] new_slot_q;

  // decode of the held entries
  logic        present, pde_large, slot_ok, valid_tab, pte_p;
  logic [9:0]  slot;
  assign present   = pde_q[D_P];
  assign pde_large = pde_q[D_PS];
  assign slot      = pde_q[17:8];
  assign slot_ok   = {1'b0, slot} < 11'(TABLE_SLOTS);
  assign valid_tab = present & ~pde_large & slot_ok;
  assign pte_p     = tab_rdata[T_P];

  logic [PTE_W-1:0] new_pte;
  assign new_pte = {us_q, wr_q, 1'b1, pa_q[31:12]};

  // execute decision
  logic             x_dir_we, x_tab_we, x_new;
  logic [DIR_W-1:0] x_dir_wdata;
  logic [PTE_W-1:0] x_tab_wdata;
  logic [2:0]       x_status;
  logic [31:0]      x_trans;
  logic             x_hit, x_inv, x_flush;

  always_comb begin
    x_dir_we    = 1'b0;
    x_tab_we    = 1'b0;
    x_new       = 1'b0;
    x_dir_wdata = pde_q;
    x_tab_wdata = '0;
    x_status    = ST_OK;
    x_trans     = '0;
    x_hit       = 1'b0;
    x_inv       = 1'b0;
    x_flush     = 1'b0;
    case (op_q)
      OP_MAP: begin
        if (pde_large) begin
          x_status = ST_LARGE;
        end else if (!present && tables_used >= USED_W'(TABLE_SLOTS)) begin
          x_status = ST_NO_SLOT;
        end else if (!present) begin
          x_new       = 1'b1;
          x_dir_we    = 1'b1;
          x_dir_wdata = '0;
          x_dir_wdata[17:8] = 10'(tables_used);
          x_dir_wdata[D_P]  = 1'b1;
          x_dir_wdata[D_RW] = 1'b1;
          x_dir_wdata[D_US] = us_q;
          x_inv       = 1'b1;
        end else begin
          // widen the directory user bit
          if (us_q) begin
            x_dir_we          = 1'b1;
            x_dir_wdata[D_US] = 1'b1;
          end
          if (!slot_ok) begin
            x_status = ST_NO_SLOT;
          end else if (pte_p) begin
            x_status = ST_MAPPED;
          end else begin
            x_tab_we    = 1'b1;
            x_tab_wdata = new_pte;
            x_inv       = 1'b1;
          end
        end
      end
      OP_UNMAP: begin
        if (!valid_tab || !pte_p) begin
          x_status = ST_NOT_MAPPED;
        end else begin
          x_tab_we = 1'b1;
          x_inv    = 1'b1;
        end
      end
      OP_PROBE: begin
        if (present && pde_large) begin
          x_trans = {slot, va_q[21:0]};
          x_hit   = 1'b1;
        end else if (valid_tab && pte_p) begin
          x_trans = {tab_rdata[19:0], va_q[11:0]};
          x_hit   = 1'b1;
        end else begin
          x_status = ST_NOT_MAPPED;
        end
      end
      OP_DROP: x_flush = 1'b1;
      OP_LOAD: begin
        x_flush     = present;
        x_dir_we    = 1'b1;
        x_dir_wdata = '0;
        x_dir_wdata[17:8] = pa_q[31:22];
        x_dir_wdata[D_PS] = 1'b1;
        x_dir_wdata[D_P]  = 1'b1;
        x_dir_wdata[D_RW] = wr_q;
        x_dir_wdata[D_US] = us_q;
      end
      default: ;
    endcase
  end

  // memory port selection
  always_comb begin
    dir_we    = cmd.clr | cmd.drop | (cmd.exec & x_dir_we);
    dir_addr  = (cmd.clr | cmd.drop) ? cnt[9:0] : di;
    dir_wdata = (cmd.clr | cmd.drop) ? '0 : x_dir_wdata;
    tab_we    = cmd.tclr | (cmd.exec & x_tab_we);
    if (cmd.tclr) begin
      tab_addr  = {new_slot_q, cnt[9:0]};
      tab_wdata = (cnt[9:0] == ti) ? new_pte : '0;
    end else begin
      tab_addr  = {pde_src[8 +: SLOT_W], ti};
      tab_wdata = x_tab_wdata;
    end
  end

  // slot counter and held results
  logic [2:0]  r_status;
  logic [31:0] r_trans;
  logic        r_hit, r_inv, r_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      tables_used <= '0;
    end else if (cmd.exec && x_new) begin
      tables_used <= tables_used + USED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      new_slot_q <= tables_used[SLOT_W-1:0];
      r_status   <= x_status;
      r_trans    <= x_trans;
      r_hit      <= x_hit;
      r_inv      <= x_inv;
      r_flush    <= x_flush;
    end
  end

  // output register
  logic out_load;
  assign out_load = cmd.done & st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= r_status;
      translated      <= r_trans;
      hit             <= r_hit;
      invalidate_page <= r_inv;
      flush_all       <= r_flush;
    end
  end

  // status to controller
  always_comb begin
    st.out_free   = ~out_valid | ~out_stall;
    st.new_slot   = cmd.exec & x_new;
    st.is_drop    = op_q == OP_DROP;
    st.drop_empty = drop_n == 11'd0;
    st.last       = cmd.drop ? (cnt == drop_n - 11'd1) : (cnt[9:0] == 10'h3FF);
  end

endmodule

// ===== src/two_level_page_table_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// Page directory and page table pool with map, unmap, probe, drop and load.
// ----------------------------------------------------------------------------
// After reset the block clears the page directory, one entry a cycle, and
// takes no transaction meanwhile. The result of an operation is offered
// after these steps: directory read, table read (both memories have
// registered reads), execute with write-back, and the result register load.
// The controller then returns to idle before a new operation is taken. A
// map that allocates a new table clears that table in a sweep that also
// writes the new entry; drop identity clears the directory entries in a
// sweep, one entry a cycle. One operation is in work at a time; the next
// is accepted while a result waits, and a result still stalled in the output
// register holds the following one back.
// ----------------------------------------------------------------------------
module two_level_page_table_manager import ptm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic        writable,
  input  logic        user_access,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] translated,
  output logic        hit,
  output logic        invalidate_page,
  output logic        flush_all
);

  // configuration register
  logic [10:0] identity_entries;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, identity_entries} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_entries <= IDENT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      identity_entries <= pwdata[10:0];
    end
  end

  cmd_t  cmd;
  stat_t st;

  ptm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .st(st), .cmd(cmd)
  );

  ptm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .identity_entries(identity_entries),
    .operation(operation), .virt_addr(virt_addr), .phys_addr(phys_addr),
    .writable(writable), .user_access(user_access),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .translated(translated), .hit(hit),
    .invalidate_page(invalidate_page), .flush_all(flush_all)
  );

endmodule

// ===== tb/sv/two_level_page_table_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager_tb
// Self-checking bench for the page table manager. Operations are queued by an
// initial block and sent in random bursts. A shadow copy of the page directory,
// the table pool and the slot counter predicts each result. A monitor compares
// the results in order while the output side stalls on its own pattern. The
// identity_entries register is changed between phases.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_tb;
  import ptm_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int IDLE_LIMIT = 12000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] ADDR_IDENT = 3'd0;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] va;
    logic [31:0] pa;
    logic        wr;
    logic        us;
  } page_op_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] xlat;
    logic        hit;
    logic        inv;
    logic        flush;
  } page_res_t;

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [2:0]  operation, status;
  logic [31:0] virt_addr, phys_addr, translated;
  logic        writable, user_access, hit, invalidate_page, flush_all;

  two_level_page_table_manager DUT (.*);

  // shadow state
  logic [DIR_W-1:0] dir_shadow [DIR_DEPTH];
  logic [PTE_W-1:0] pte_shadow [TABLE_SLOTS*TAB_LEN];
  int unsigned      slots_taken;
  logic [10:0]      ident_shadow;

  page_op_t  op_queue [$];
  page_res_t result_queue [$];
  int unsigned n_accepted, n_checked, n_errors, n_hits, n_maps, n_no_slot;
  int unsigned idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  // shadow model of one operation
  function automatic page_res_t translate_op(page_op_t t);
    page_res_t r;
    logic [9:0] di, ti, slot;
    logic [DIR_W-1:0] pde;
    int unsigned base, n;
    logic tab_ok;
    r = '0;
    di = t.va[31:22];
    ti = t.va[21:12];
    pde = dir_shadow[di];
    case (t.op)
      OP_MAP: begin
        if (pde[D_PS]) begin
          r.st = ST_LARGE;
        end else if (!pde[D_P] && slots_taken >= TABLE_SLOTS) begin
          r.st = ST_NO_SLOT;
        end else begin
          if (!pde[D_P]) begin
            for (int i = 0; i < TAB_LEN; i++) pte_shadow[slots_taken*TAB_LEN + i] = '0;
            dir_shadow[di] = '0;
            dir_shadow[di][17:8] = 10'(slots_taken);
            dir_shadow[di][D_P] = 1'b1;
            dir_shadow[di][D_RW] = 1'b1;
            dir_shadow[di][D_US] = t.us;
            slots_taken++;
          end else if (t.us) begin
            dir_shadow[di][D_US] = 1'b1;
          end
          slot = dir_shadow[di][17:8];
          base = slot * TAB_LEN;
          if (slot >= TABLE_SLOTS) begin
            r.st = ST_NO_SLOT;
          end else if (pte_shadow[base + ti][T_P]) begin
            r.st = ST_MAPPED;
          end else begin
            pte_shadow[base + ti] = {t.us, t.wr, 1'b1, t.pa[31:12]};
            r.inv = 1'b1;
            n_maps++;
          end
        end
      end
      OP_UNMAP, OP_PROBE: begin
        slot = pde[17:8];
        base = slot * TAB_LEN;
        tab_ok = pde[D_P] && !pde[D_PS] && slot < TABLE_SLOTS;
        if (t.op == OP_PROBE && pde[D_P] && pde[D_PS]) begin
          r.xlat = {slot, t.va[21:0]};
          r.hit = 1'b1;
        end else if (!tab_ok || !pte_shadow[base + ti][T_P]) begin
          r.st = ST_NOT_MAPPED;
        end else if (t.op == OP_UNMAP) begin
          pte_shadow[base + ti] = '0;
          r.inv = 1'b1;
        end else begin
          r.xlat = {pte_shadow[base + ti][19:0], t.va[11:0]};
          r.hit = 1'b1;
        end
      end
      OP_DROP: begin
        n = (ident_shadow > DIR_COUNT) ? DIR_COUNT : ident_shadow;
        for (int i = 0; i < n; i++) dir_shadow[i] = '0;
        r.flush = 1'b1;
      end
      OP_LOAD: begin
        r.flush = pde[D_P];
        dir_shadow[di] = '0;
        dir_shadow[di][17:8] = t.pa[31:22];
        dir_shadow[di][D_PS] = 1'b1;
        dir_shadow[di][D_P] = 1'b1;
        dir_shadow[di][D_RW] = t.wr;
        dir_shadow[di][D_US] = t.us;
      end
      default: ;
    endcase
    if (r.hit) n_hits++;
    if (r.st == ST_NO_SLOT) n_no_slot++;
    return r;
  endfunction

  // sender: random bursts and gaps, prediction on every accepted transaction
  int unsigned burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        result_queue.push_back(translate_op({operation, virt_addr, phys_addr,
                                             writable, user_access}));
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (op_queue.size() > 0) begin
          page_op_t t;
          t = op_queue.pop_front();
          in_valid <= 1'b1;
          operation <= t.op;
          virt_addr <= t.va;
          phys_addr <= t.pa;
          writable <= t.wr;
          user_access <= t.us;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stretches of no stall and random stall, one long hold-off
  int unsigned stretch_left, hold_left;
  logic stall_mode, hold_done;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stretch_left = 50;
      stall_mode = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && n_accepted >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 120);
        stall_mode = ~stall_mode;
      end else begin
        stretch_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= stall_mode && ($urandom_range(0, 2) == 0);
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result status=%0d translated=%h", $time, status,
                 translated);
        n_errors++;
      end else begin
        page_res_t e;
        e = result_queue.pop_front();
        n_checked++;
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          n_errors++;
        end
        if (translated !== e.xlat) begin
          $display("%0t: translated expected %h actual %h", $time, e.xlat, translated);
          n_errors++;
        end
        if (hit !== e.hit) begin
          $display("%0t: hit expected %b actual %b", $time, e.hit, hit);
          n_errors++;
        end
        if (invalidate_page !== e.inv) begin
          $display("%0t: invalidate_page expected %b actual %b", $time, e.inv,
                   invalidate_page);
          n_errors++;
        end
        if (flush_all !== e.flush) begin
          $display("%0t: flush_all expected %b actual %b", $time, e.flush, flush_all);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any input or output transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_op(logic [2:0] op, logic [31:0] va, logic [31:0] pa,
                         logic wr, logic us);
    op_queue.push_back({op, va, pa, wr, us});
  endtask

  // directory indexes that the random part keeps returning to
  function automatic logic [9:0] pick_dir();
    logic [9:0] pool [12];
    pool = '{10'd0, 10'd1, 10'd2, 10'd100, 10'd223, 10'd224, 10'd225, 10'd511,
             10'd512, 10'd700, 10'd1022, 10'd1023};
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 11)];
    return 10'($urandom);
  endfunction

  task automatic push_random(int unsigned count);
    int unsigned w;
    logic [2:0] op;
    logic [9:0] ti;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 36)      op = OP_MAP;
      else if (w < 52) op = OP_UNMAP;
      else if (w < 88) op = OP_PROBE;
      else if (w < 95) op = OP_LOAD;
      else if (w < 97) op = OP_DROP;
      else             op = 3'($urandom_range(5, 7));
      ti = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 7)) : 10'($urandom);
      push_op(op, {pick_dir(), ti, 12'($urandom)}, $urandom, 1'($urandom),
              1'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (op_queue.size() > 0 || in_valid || result_queue.size() > 0)
      @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_ident(logic [10:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_IDENT;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    ident_shadow = value;
  endtask

  // stimulus and end of run
  initial begin
    logic [10:0] ident_values [4];
    ident_values = '{11'd0, 11'd1024, 11'd5, 11'd300};
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; operation = '0; virt_addr = '0; phys_addr = '0;
    writable = 1'b0; user_access = 1'b0; out_stall = 1'b0;
    for (int i = 0; i < DIR_DEPTH; i++) dir_shadow[i] = '0;
    slots_taken = 0;
    ident_shadow = IDENT_RESET;
    n_accepted = 0; n_checked = 0; n_errors = 0; n_hits = 0; n_maps = 0;
    n_no_slot = 0; idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: every operation and the corner cases
    push_op(OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_op(OP_PROBE, 32'h0000_0FFF, 32'h0, 1'b0, 1'b0);
    push_op(OP_MAP,   32'h0000_0123, 32'h1234_5000, 1'b0, 1'b1);  // remap, widens user
    push_op(OP_UNMAP, 32'h0000_0000, 32'h0, 1'b0, 1'b0);
    push_op(OP_UNMAP, 32'h0000_0000, 32'h0, 1'b0, 1'b0);          // not mapped
    push_op(OP_PROBE, 32'h0000_0000, 32'h0, 1'b0, 1'b0);          // miss
    push_op(OP_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
    push_op(OP_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
    push_op(OP_LOAD,  32'h0040_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);  // large on empty
    push_op(OP_PROBE, 32'h007F_FFFF, 32'h0, 1'b0, 1'b0);
    push_op(OP_MAP,   32'h0040_1000, 32'h5555_5000, 1'b1, 1'b1);  // onto large page
    push_op(OP_UNMAP, 32'h0040_1000, 32'h0, 1'b0, 1'b0);          // unmap large
    push_op(OP_LOAD,  32'hFFC0_0000, 32'h8000_0000, 1'b0, 1'b0);  // over a table
    push_op(OP_PROBE, 32'hFFC0_1ABC, 32'h0, 1'b0, 1'b0);
    push_op(OP_LOAD,  32'h0040_0000, 32'h003F_FFFF, 1'b0, 1'b0);  // over a large page
    push_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_op(3'd6, 32'h0, 32'h0, 1'b0, 1'b0);
    push_op(3'd7, 32'h1234_5678, 32'h0, 1'b1, 1'b0);
    push_op(OP_DROP, 32'h0, 32'h0, 1'b0, 1'b0);
    push_op(OP_PROBE, 32'h0040_0000, 32'h0, 1'b0, 1'b0);
    push_random(360);

    // further phases under different identity_entries settings
    foreach (ident_values[k]) begin
      wait_idle();
      write_ident(ident_values[k]);
      push_op(OP_DROP, 32'h0, 32'h0, 1'b0, 1'b0);
      push_random(300);
    end

    wait_idle();
    if (result_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, result_queue.size());
      n_errors++;
    end
    $display("Ran %0d operations, checked %0d results: %0d hits, %0d pages mapped,",
             n_accepted, n_checked, n_hits, n_maps);
    $display("%0d maps refused for an empty pool, five identity settings, %0d errors",
             n_no_slot, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== two_level_page_table_manager.f =====
src/ptm_pkg.sv
src/ptm_ram.sv
src/ptm_ctrl.sv
src/ptm_datapath.sv
src/two_level_page_table_manager.sv
tb/sv/two_level_page_table_manager_tb.sv
